>>> sv/afr_pkg.sv
// Shared types, constants and codes for the anemometer frame receiver.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package afr_pkg;

    // Frame store and counter widths.
    localparam int FRAME_BITS  = 41;
    localparam int IDX_W       = $clog2(FRAME_BITS + 1);
    localparam int TIME_W      = 20;
    localparam int LEN_W       = 16;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_LENGTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EARLY_MARGIN  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LATE_MARGIN   = 2'd3;

    // Configuration reset values.
    localparam logic [LEN_W-1:0]  BIT_LENGTH_RST    = 16'd1200;
    localparam logic [TIME_W-1:0] WINDOW_LENGTH_RST = 20'd50000;
    localparam logic [LEN_W-1:0]  EARLY_MARGIN_RST  = 16'd100;
    localparam logic [LEN_W-1:0]  LATE_MARGIN_RST   = 16'd900;

    // Frame layout, bit 0 first on the wire.
    localparam int HDR_POS  = 0;
    localparam int DIR_POS  = 5;
    localparam int SPD_POS  = 9;
    localparam int SUM_POS  = 21;
    localparam int NDIR_POS = 25;
    localparam int NSPD_POS = 29;
    localparam logic [4:0]  FRAME_HEADER = 5'd27;
    localparam logic [3:0]  NIBBLE_MASK  = 4'hf;
    localparam logic [11:0] SPEED_MASK   = 12'hfff;

    // Request types.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Error codes.
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_HEADER   = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;
    localparam logic [1:0] ERR_COPY     = 2'd3;

    typedef struct packed {
        logic req_type;
        logic line_level;
    } sample_t;

    typedef struct packed {
        logic        frame_ok;
        logic [1:0]  error_code;
        logic [3:0]  direction;
        logic [11:0] speed_tenths;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAPTURE,
        ST_DECODE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic tick;
        logic load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic window_end;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> sv/afr_ctrl.sv
// Controller of the anemometer frame receiver: capture window state machine.
// Depends on afr_pkg for the state type and the command and status structs.
`default_nettype none

module afr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    input  wire logic               req_type,
    input  wire afr_pkg::dp_status_t status,
    output      logic               sample_ready,
    output      afr_pkg::ctrl_cmd_t cmd
);

    afr_pkg::state_t state_reg;
    afr_pkg::state_t state_next;
    logic            accept;

    assign accept = sample_valid && sample_ready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= afr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            afr_pkg::ST_IDLE:
            begin
                if (accept && req_type == afr_pkg::REQ_START)
                begin
                    state_next = afr_pkg::ST_CAPTURE;
                end
            end
            afr_pkg::ST_CAPTURE:
            begin
                if (accept && req_type == afr_pkg::REQ_TICK && status.window_end)
                begin
                    state_next = afr_pkg::ST_DECODE;
                end
            end
            afr_pkg::ST_DECODE:
            begin
                if (status.out_free)
                begin
                    state_next = afr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = afr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: the sample side stalls only while the frame is being decoded.
    always_comb
    begin
        sample_ready = 1'b1;
        cmd          = '0;
        case (state_reg)
            afr_pkg::ST_IDLE:
            begin
                cmd.clear = sample_valid && req_type == afr_pkg::REQ_START;
            end
            afr_pkg::ST_CAPTURE:
            begin
                cmd.clear = sample_valid && req_type == afr_pkg::REQ_START;
                cmd.tick  = sample_valid && req_type == afr_pkg::REQ_TICK;
            end
            afr_pkg::ST_DECODE:
            begin
                sample_ready = 1'b0;
                cmd.load     = status.out_free;
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/afr_datapath.sv
// Datapath of the anemometer frame receiver: configuration, bit timing,
// frame store, decoder and result register. Depends on afr_pkg.
`default_nettype none

module afr_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [afr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [afr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                line_level,
    input  wire afr_pkg::ctrl_cmd_t                  cmd,
    input  wire logic                                result_ready,
    output      afr_pkg::dp_status_t                 status,
    output      logic                                result_valid,
    output      afr_pkg::result_t                    result
);

    localparam int TW = afr_pkg::TIME_W;
    localparam int LW = afr_pkg::LEN_W;
    localparam int XW = afr_pkg::IDX_W;
    localparam logic [XW-1:0] IDX_LIMIT = XW'(afr_pkg::FRAME_BITS);

    // Configuration registers.
    logic [LW-1:0] bit_len_reg;
    logic [TW-1:0] window_reg;
    logic [LW-1:0] early_reg;
    logic [LW-1:0] late_reg;

    // Capture state. Phase and bit index track time modulo and over the
    // bit period, so no divider is needed.
    logic [TW-1:0]                  time_reg;
    logic [TW-1:0]                  time_next;
    logic [LW-1:0]                  phase_reg;
    logic [LW-1:0]                  phase_next;
    logic [XW-1:0]                  idx_reg;
    logic [XW-1:0]                  idx_next;
    logic                           prev_level_reg;
    logic [afr_pkg::FRAME_BITS-1:0] bits_reg;
    logic [afr_pkg::FRAME_BITS-1:0] bits_next;

    logic               result_valid_reg;
    afr_pkg::result_t   result_reg;
    afr_pkg::result_t   result_next;

    logic [LW-1:0] len_eff;
    logic [LW-1:0] half_len;
    logic [LW-1:0] gap;
    logic          sample_hit;
    logic          level_change;
    logic          snap_back;
    logic          snap_fwd;
    logic [TW-1:0] time_base;
    logic [TW:0]   time_sum;
    logic [LW-1:0] phase_adj;
    logic [LW:0]   phase_inc;
    logic          phase_wrap;
    logic [XW-1:0] idx_step;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_len_reg <= afr_pkg::BIT_LENGTH_RST;
            window_reg  <= afr_pkg::WINDOW_LENGTH_RST;
            early_reg   <= afr_pkg::EARLY_MARGIN_RST;
            late_reg    <= afr_pkg::LATE_MARGIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                afr_pkg::CFG_BIT_LENGTH:    bit_len_reg <= cfg_data[LW-1:0];
                afr_pkg::CFG_WINDOW_LENGTH: window_reg  <= cfg_data[TW-1:0];
                afr_pkg::CFG_EARLY_MARGIN:  early_reg   <= cfg_data[LW-1:0];
                afr_pkg::CFG_LATE_MARGIN:   late_reg    <= cfg_data[LW-1:0];
                default:                    bit_len_reg <= bit_len_reg;
            endcase
        end
    end

    // Bit timing: sampling decision, edge realignment and time advance.
    always_comb
    begin
        len_eff      = (bit_len_reg == '0) ? LW'(1) : bit_len_reg;
        half_len     = len_eff >> 1;
        gap          = len_eff - phase_reg;
        sample_hit   = (phase_reg > half_len) && (idx_reg < IDX_LIMIT);
        level_change = line_level != prev_level_reg;
        snap_back    = level_change && (phase_reg < early_reg);
        snap_fwd     = level_change && !snap_back && (phase_reg > late_reg);

        time_base = snap_back ? (time_reg - TW'(phase_reg)) : time_reg;
        time_sum  = {1'b0, time_base} + (snap_fwd ? (TW + 1)'(gap) : '0)
                  + (TW + 1)'(1);
        time_next = time_sum[TW] ? afr_pkg::TIME_MAX : time_sum[TW-1:0];

        // After a realignment the phase sits on a boundary.
        phase_adj  = (snap_back || snap_fwd) ? '0 : phase_reg;
        idx_step   = (snap_fwd && idx_reg < IDX_LIMIT) ? idx_reg + XW'(1) : idx_reg;
        phase_inc  = {1'b0, phase_adj} + (LW + 1)'(1);
        phase_wrap = phase_inc == {1'b0, len_eff};
        phase_next = phase_wrap ? '0 : phase_inc[LW-1:0];
        idx_next   = (phase_wrap && idx_step < IDX_LIMIT) ? idx_step + XW'(1) : idx_step;
    end

    // Frame store: the sample lands on the bit under the current index.
    always_comb
    begin
        for (int i = 0; i < afr_pkg::FRAME_BITS; i++)
        begin
            bits_next[i] = (sample_hit && idx_reg == XW'(i)) ? line_level : bits_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            phase_reg      <= '0;
            idx_reg        <= '0;
            prev_level_reg <= 1'b1;
            bits_reg       <= '0;
        end
        else if (cmd.clear)
        begin
            time_reg       <= '0;
            phase_reg      <= '0;
            idx_reg        <= '0;
            prev_level_reg <= 1'b1;
            bits_reg       <= '0;
        end
        else if (cmd.tick)
        begin
            time_reg       <= time_next;
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            prev_level_reg <= line_level;
            bits_reg       <= bits_next;
        end
    end

    // Frame decoder: header, nibble checksum, then the inverted copies.
    always_comb
    begin
        logic [4:0]  hdr;
        logic [3:0]  dir;
        logic [11:0] spd;
        logic [3:0]  sum;
        logic [3:0]  ndir;
        logic [11:0] nspd;
        logic [3:0]  csum;
        logic [1:0]  err;

        hdr  = bits_reg[afr_pkg::HDR_POS +: 5];
        dir  = bits_reg[afr_pkg::DIR_POS +: 4];
        spd  = bits_reg[afr_pkg::SPD_POS +: 12];
        sum  = bits_reg[afr_pkg::SUM_POS +: 4];
        ndir = bits_reg[afr_pkg::NDIR_POS +: 4] ^ afr_pkg::NIBBLE_MASK;
        nspd = bits_reg[afr_pkg::NSPD_POS +: 12] ^ afr_pkg::SPEED_MASK;
        csum = dir + spd[3:0] + spd[7:4] + spd[11:8];

        if (hdr != afr_pkg::FRAME_HEADER)
        begin
            err = afr_pkg::ERR_HEADER;
        end
        else if (csum != sum)
        begin
            err = afr_pkg::ERR_CHECKSUM;
        end
        else if (spd != nspd || dir != ndir)
        begin
            err = afr_pkg::ERR_COPY;
        end
        else
        begin
            err = afr_pkg::ERR_OK;
        end

        result_next.frame_ok     = err == afr_pkg::ERR_OK;
        result_next.error_code   = err;
        result_next.direction    = (err == afr_pkg::ERR_OK) ? dir : '0;
        result_next.speed_tenths = (err == afr_pkg::ERR_OK) ? spd : '0;
    end

    // Result register: holds one word until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            result_reg <= result_next;
        end
    end

    assign status.window_end = time_sum >= {1'b0, window_reg};
    assign status.out_free   = !result_valid_reg || result_ready;
    assign result_valid      = result_valid_reg;
    assign result            = result_reg;

endmodule

`default_nettype wire

>>> sv/anemometer_frame_receiver.sv
// Top level of the anemometer frame receiver: controller plus datapath.
// Depends on afr_pkg, afr_ctrl and afr_datapath.
//
// A start word opens a capture window; each tick word after it carries one
// sample of the sensor's data wire and is accepted while capturing, so one
// tick per clock is sustained for the whole window. The tick that ends the
// window is followed by the decode state, during which sample_ready is low;
// that state lasts for as long as an earlier result still sits unread
// in the output register, which is the only place a result waits. Bit timing
// keeps the phase within the bit period and the bit index as running
// counters beside the elapsed time. Configuration is written through
// cfg_write, cfg_index and cfg_data and should change only while idle.
`default_nettype none

module anemometer_frame_receiver (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [afr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [afr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            sample_valid,
    output      logic                            sample_ready,
    input  wire afr_pkg::sample_t                sample,
    output      logic                            result_valid,
    input  wire logic                            result_ready,
    output      afr_pkg::result_t                result
);

    afr_pkg::ctrl_cmd_t  cmd;
    afr_pkg::dp_status_t status;

    // Window state machine.
    afr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .req_type     (sample.req_type),
        .status       (status),
        .sample_ready (sample_ready),
        .cmd          (cmd)
    );

    // Timing, store and decoder.
    afr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .line_level   (sample.line_level),
        .cmd          (cmd),
        .result_ready (result_ready),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> sv/afr_checker.sv
// Port-level checks for the anemometer frame receiver, bound to its top.
// Depends on afr_pkg for the error codes.
`default_nettype none

module afr_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             sample_ready,
    input wire logic             result_valid,
    input wire logic             result_ready,
    input wire afr_pkg::result_t result
);

    // A result word waiting for the sink holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed or dropped while stalled");

    // The good-frame flag agrees with the error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.frame_ok == (result.error_code == afr_pkg::ERR_OK))
        else $error("frame_ok disagrees with error_code");

    // A failed frame reports neither direction nor speed.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.error_code != afr_pkg::ERR_OK
            |-> result.direction == '0 && result.speed_tenths == '0)
        else $error("failed frame carries data");

    // A new result only appears after a decode cycle with the sample side stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(sample_ready))
        else $error("result appeared without a decode cycle");

endmodule

bind anemometer_frame_receiver afr_checker u_afr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

>>> dv/anemometer_frame_receiver_tb.sv
// Self-checking testbench for the anemometer frame receiver.
// Needs afr_pkg and anemometer_frame_receiver; a scoreboard class predicts each decoded frame.
`timescale 1ns / 100ps

class wind_frame_scoreboard;
    // Working copy of the timing registers.
    logic [afr_pkg::LEN_W-1:0]      bit_len;
    logic [afr_pkg::TIME_W-1:0]     window_len;
    logic [afr_pkg::LEN_W-1:0]      early_m;
    logic [afr_pkg::LEN_W-1:0]      late_m;
    // Working copy of the capture state.
    logic [afr_pkg::TIME_W-1:0]     elapsed;
    logic                           prev_level;
    logic [afr_pkg::FRAME_BITS-1:0] frame_bits;
    bit                             capturing;
    // Decoded frames still owed by the block.
    afr_pkg::result_t               due_frames[$];
    int unsigned                    mismatches;
    int unsigned                    words_used;
    int unsigned                    frames_seen;

    function new();
        bit_len     = afr_pkg::BIT_LENGTH_RST;
        window_len  = afr_pkg::WINDOW_LENGTH_RST;
        early_m     = afr_pkg::EARLY_MARGIN_RST;
        late_m      = afr_pkg::LATE_MARGIN_RST;
        elapsed     = '0;
        prev_level  = 1'b1;
        frame_bits  = '0;
        capturing   = 1'b0;
        mismatches  = 0;
        words_used  = 0;
        frames_seen = 0;
    endfunction

    function void set_reg(logic [afr_pkg::CFG_INDEX_W-1:0] idx,
                          logic [afr_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            afr_pkg::CFG_BIT_LENGTH:    bit_len    = val[afr_pkg::LEN_W-1:0];
            afr_pkg::CFG_WINDOW_LENGTH: window_len = val[afr_pkg::TIME_W-1:0];
            afr_pkg::CFG_EARLY_MARGIN:  early_m    = val[afr_pkg::LEN_W-1:0];
            default:                    late_m     = val[afr_pkg::LEN_W-1:0];
        endcase
    endfunction

    // Header first, then checksum, then the inverted copies; fields are zeroed on error.
    function afr_pkg::result_t decode_capture();
        logic [4:0]       hdr;
        logic [3:0]       dir;
        logic [3:0]       sum;
        logic [3:0]       ndir;
        logic [3:0]       csum;
        logic [11:0]      spd;
        logic [11:0]      nspd;
        afr_pkg::result_t r;
        hdr  = frame_bits[afr_pkg::HDR_POS +: 5];
        dir  = frame_bits[afr_pkg::DIR_POS +: 4];
        spd  = frame_bits[afr_pkg::SPD_POS +: 12];
        sum  = frame_bits[afr_pkg::SUM_POS +: 4];
        ndir = frame_bits[afr_pkg::NDIR_POS +: 4] ^ afr_pkg::NIBBLE_MASK;
        nspd = frame_bits[afr_pkg::NSPD_POS +: 12] ^ afr_pkg::SPEED_MASK;
        csum = dir + spd[3:0] + spd[7:4] + spd[11:8];
        r = '0;
        if (hdr != afr_pkg::FRAME_HEADER)
            r.error_code = afr_pkg::ERR_HEADER;
        else if (csum != sum)
            r.error_code = afr_pkg::ERR_CHECKSUM;
        else if (spd != nspd || dir != ndir)
            r.error_code = afr_pkg::ERR_COPY;
        else
        begin
            r.frame_ok     = 1'b1;
            r.error_code   = afr_pkg::ERR_OK;
            r.direction    = dir;
            r.speed_tenths = spd;
        end
        return r;
    endfunction

    // Advances the capture state by one accepted word.
    function void note_sample(afr_pkg::sample_t w);
        int unsigned len;
        int unsigned t;
        int unsigned phase;
        int unsigned idx;
        words_used++;
        if (w.req_type == afr_pkg::REQ_START)
        begin
            elapsed    = '0;
            prev_level = 1'b1;
            frame_bits = '0;
            capturing  = 1'b1;
            return;
        end
        if (!capturing)
            return;
        len   = (bit_len == 0) ? 1 : bit_len;
        t     = elapsed;
        phase = t % len;
        idx   = t / len;
        if (phase > len / 2 && idx < afr_pkg::FRAME_BITS)
            frame_bits[idx] = w.line_level;
        // An edge pulls the time back to the boundary or on to the next one.
        if (w.line_level != prev_level)
        begin
            if (phase < early_m)
                t = t - phase;
            else if (phase > late_m)
                t = t + (len - phase);
            prev_level = w.line_level;
        end
        t = t + 1;
        elapsed = (t > afr_pkg::TIME_MAX) ? afr_pkg::TIME_MAX : t[afr_pkg::TIME_W-1:0];
        if (t >= window_len)
        begin
            capturing = 1'b0;
            due_frames.push_back(decode_capture());
        end
    endfunction

    task report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task check_result(afr_pkg::result_t got);
        afr_pkg::result_t want;
        if (due_frames.size() == 0)
        begin
            report($sformatf("result %h with no frame pending", got));
            return;
        end
        want = due_frames.pop_front();
        frames_seen++;
        if (got.frame_ok !== want.frame_ok)
            report($sformatf("frame_ok got %b want %b", got.frame_ok, want.frame_ok));
        if (got.error_code !== want.error_code)
            report($sformatf("error_code got %0d want %0d", got.error_code, want.error_code));
        if (got.direction !== want.direction)
            report($sformatf("direction got %0d want %0d", got.direction, want.direction));
        if (got.speed_tenths !== want.speed_tenths)
            report($sformatf("speed_tenths got %0d want %0d",
                             got.speed_tenths, want.speed_tenths));
    endtask
endclass

module anemometer_frame_receiver_tb;

    // The limit sits well above the slowest correct run, even with every word
    // behind the longest sender gap.
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int WORD_TARGET   = 1250;

    // Frame damage, as a mask.
    localparam int FLAW_HEADER = 1;
    localparam int FLAW_SUM    = 2;
    localparam int FLAW_COPY   = 4;
    localparam int FLAW_NOISE  = 8;

    // Result sink behaviour.
    localparam int SINK_OPEN    = 0;
    localparam int SINK_COIN    = 1;
    localparam int SINK_PATTERN = 2;
    localparam int SINK_SPARSE  = 3;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_write    = 1'b0;
    logic [afr_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [afr_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                            sample_valid = 1'b0;
    logic                            sample_ready;
    afr_pkg::sample_t                sample       = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    afr_pkg::result_t                result;

    wind_frame_scoreboard sb;
    bit                   gaps_on;
    int                   burst_left;
    bit                   hold_req;
    int unsigned          cycle_count;

    always #1 clk = ~clk;

    anemometer_frame_receiver u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Offers one word and waits for it to be taken; valid stays high afterwards.
    task automatic put_word(logic req, logic level);
        afr_pkg::sample_t w;
        int unsigned      gap;
        if (gaps_on && burst_left <= 0)
        begin
            gap = $urandom_range(1, 8);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 64);
        end
        burst_left--;
        w.req_type   = req;
        w.line_level = level;
        sample       <= w;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(sample_valid && sample_ready));
        sb.note_sample(w);
    endtask

    // Stops offering words and waits until every decoded frame is back.
    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.due_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [afr_pkg::CFG_INDEX_W-1:0] idx, int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[afr_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        sb.set_reg(idx, val[afr_pkg::CFG_DATA_W-1:0]);
    endtask

    task automatic set_timing(int unsigned bl, int unsigned wl, int unsigned em,
                              int unsigned lm);
        write_reg(afr_pkg::CFG_BIT_LENGTH, bl);
        write_reg(afr_pkg::CFG_WINDOW_LENGTH, wl);
        write_reg(afr_pkg::CFG_EARLY_MARGIN, em);
        write_reg(afr_pkg::CFG_LATE_MARGIN, lm);
        cfg_write <= 1'b0;
    endtask

    // Builds a 41-bit frame with random contents and the requested damage.
    function automatic logic [afr_pkg::FRAME_BITS-1:0] make_frame(int unsigned flaw);
        logic [3:0]                     dir;
        logic [3:0]                     sum;
        logic [11:0]                    spd;
        logic [63:0]                    raw;
        logic [afr_pkg::FRAME_BITS-1:0] f;
        dir = 4'($urandom_range(0, 15));
        spd = 12'($urandom_range(0, 4095));
        sum = dir + spd[3:0] + spd[7:4] + spd[11:8];
        f = '0;
        f[afr_pkg::HDR_POS +: 5]   = afr_pkg::FRAME_HEADER;
        f[afr_pkg::DIR_POS +: 4]   = dir;
        f[afr_pkg::SPD_POS +: 12]  = spd;
        f[afr_pkg::SUM_POS +: 4]   = sum;
        f[afr_pkg::NDIR_POS +: 4]  = ~dir;
        f[afr_pkg::NSPD_POS +: 12] = ~spd;
        if (flaw & FLAW_HEADER)
            f[afr_pkg::HDR_POS + $urandom_range(0, 4)] ^= 1'b1;
        if (flaw & FLAW_SUM)
            f[afr_pkg::SUM_POS + $urandom_range(0, 3)] ^= 1'b1;
        if (flaw & FLAW_COPY)
            f[afr_pkg::NDIR_POS + $urandom_range(0, 15)] ^= 1'b1;
        if (flaw & FLAW_NOISE)
        begin
            raw = {$urandom, $urandom};
            f   = raw[afr_pkg::FRAME_BITS-1:0];
        end
        return f;
    endfunction

    // Sends a start and then the frame as a waveform, each bit held for about
    // one period with some jitter, then idles high until the window closes.
    task automatic send_frame(logic [afr_pkg::FRAME_BITS-1:0] f, int unsigned len,
                              int unsigned jit);
        int per;
        put_word(afr_pkg::REQ_START, 1'($urandom_range(0, 1)));
        for (int i = 0; i < afr_pkg::FRAME_BITS && sb.capturing; i++)
        begin
            per = int'(len) + int'($urandom_range(0, 2 * jit)) - int'(jit);
            if (per < 1)
                per = 1;
            for (int k = 0; k < per && sb.capturing; k++)
                put_word(afr_pkg::REQ_TICK, f[i]);
        end
        while (sb.capturing)
            put_word(afr_pkg::REQ_TICK, 1'b1);
    endtask

    task automatic frame_phase();
        int unsigned len;
        int unsigned win;
        int unsigned early;
        int unsigned late;
        int unsigned frames;
        len    = $urandom_range(16, 24);
        frames = $urandom_range(1, 2);
        // The window closes partway through the frame, so that a phase stays short.
        win = $urandom_range(1, 6 * len);
        if ($urandom_range(0, 3) != 0)
        begin
            early = len / 4;
            late  = len - len / 4;
        end
        else
        begin
            early = $urandom_range(0, len);
            late  = $urandom_range(0, len);
        end
        set_timing(len, win, early, late);
        repeat (frames)
            send_frame(make_frame(($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 15)),
                       len, $urandom_range(0, len / 8));
    endtask

    // Short windows and random line activity, with the odd restart.
    task automatic noise_phase();
        int unsigned len;
        int unsigned n;
        logic        level;
        len = $urandom_range(16, 64);
        set_timing(len,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40),
                   ($urandom_range(0, 7) == 0) ? 16'hffff : $urandom_range(0, len),
                   ($urandom_range(0, 7) == 0) ? 16'hffff : $urandom_range(0, len));
        n = $urandom_range(30, 60);
        level = 1'b1;
        repeat (n)
        begin
            if ($urandom_range(0, 11) == 0)
                put_word(afr_pkg::REQ_START, 1'($urandom_range(0, 1)));
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    level = ~level;
                put_word(afr_pkg::REQ_TICK, level);
            end
        end
        // A steady line always lets the window run out.
        while (sb.capturing)
            put_word(afr_pkg::REQ_TICK, level);
    endtask

    // Result sink: checks every word taken; stalls by random mode or a requested hold.
    initial
    begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        logic [7:0]  pattern;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        pattern   = 8'b1011_0010;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                sb.check_result(result);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(SINK_OPEN, SINK_SPARSE);
                mode_left = $urandom_range(64, 512);
                pattern   = 8'($urandom);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_OPEN:    result_ready <= 1'b1;
                    SINK_COIN:    result_ready <= 1'($urandom_range(0, 1));
                    SINK_PATTERN:
                    begin
                        result_ready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                    default:      result_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Cycle limit.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        logic level;
        sb         = new();
        gaps_on    = 1'b0;
        burst_left = 0;
        hold_req   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A tick while idle is ignored.
        put_word(afr_pkg::REQ_TICK, 1'b0);
        drain();

        // One clean full-length frame with even bit periods.
        set_timing(16, afr_pkg::FRAME_BITS * 16 + 8, 4, 12);
        send_frame(make_frame(0), 16, 0);
        drain();

        // Shortest window: the first tick after each start closes it.
        set_timing(16, 1, 0, 0);
        put_word(afr_pkg::REQ_START, 1'b0);
        put_word(afr_pkg::REQ_TICK, 1'b0);
        put_word(afr_pkg::REQ_TICK, 1'b1);
        put_word(afr_pkg::REQ_START, 1'b1);
        put_word(afr_pkg::REQ_TICK, 1'b1);
        drain();

        // A zero bit period behaves as a period of one tick.
        set_timing(0, 3, 0, 0);
        put_word(afr_pkg::REQ_START, 1'b1);
        put_word(afr_pkg::REQ_TICK, 1'b0);
        put_word(afr_pkg::REQ_TICK, 1'b1);
        put_word(afr_pkg::REQ_TICK, 1'b0);
        drain();

        // Longest period and window; every edge but the first jumps to the next boundary,
        // so time runs past its maximum and saturates.
        set_timing(16'hffff, 20'hfffff, 0, 0);
        put_word(afr_pkg::REQ_START, 1'b1);
        level = 1'b0;
        while (sb.capturing)
        begin
            put_word(afr_pkg::REQ_TICK, level);
            level = ~level;
        end
        drain();

        // Widest margins over a short window: every edge snaps back to its boundary.
        set_timing(16, 8 * 16, 16'hffff, 16'hffff);
        send_frame(make_frame(0), 16, 2);
        drain();

        // Hold the sink off while short windows keep arriving, so that the
        // output fills and the block stalls its input.
        set_timing(16, 2, 0, 0);
        hold_req = 1'b1;
        repeat (24)
        begin
            put_word(afr_pkg::REQ_START, 1'($urandom_range(0, 1)));
            put_word(afr_pkg::REQ_TICK, 1'b0);
            put_word(afr_pkg::REQ_TICK, 1'b1);
        end
        drain();

        // Random phases, each ending with the block idle.
        while (sb.words_used < WORD_TARGET)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6)
                frame_phase();
            else
                noise_phase();
            drain();
        end

        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> files.f
sv/afr_pkg.sv
sv/afr_ctrl.sv
sv/afr_datapath.sv
sv/anemometer_frame_receiver.sv
sv/afr_checker.sv
dv/anemometer_frame_receiver_tb.sv
